[src/tplru_pkg.sv]
// Shared types and constants for the tree pseudo-LRU replacement core.
// No dependencies.
package tplru_pkg;

  localparam int unsigned SETS   = 2048;
  localparam int unsigned WAYS   = 16;
  localparam int unsigned DEPTH  = 4;            // floor(log2(WAYS))
  localparam int unsigned SET_W  = 11;           // set_index field width
  localparam int unsigned WAY_W  = 4;            // way and victim_way field width
  localparam int unsigned TREE_W = WAYS - 1;     // node bits per set
  localparam int unsigned NODE_W = 4;            // index into the node bits
  localparam int unsigned CLR_W  = SET_W + 1;    // clear sweep counter

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_TOUCH = 1'b1
  } op_e;

  typedef logic [TREE_W-1:0] tree_t;

  // Request held in the read stage while the tree word comes out of memory.
  typedef struct packed {
    op_e              op;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;
  } req_t;

endpackage

[src/tplru_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tplru_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/tplru_tree.sv]
// Tree walk for one set: victim lookup and touch update of the node bits.
// Depends on tplru_pkg.
module tplru_tree (
  input  tplru_pkg::tree_t                 bits_i,
  input  logic [tplru_pkg::WAY_W-1:0]      way_i,
  output logic [tplru_pkg::WAY_W-1:0]      victim_o,
  output tplru_pkg::tree_t                 bits_o
);

  logic [tplru_pkg::NODE_W-1:0] vnode;
  logic [tplru_pkg::NODE_W-1:0] tnode;
  logic                         vb;
  logic                         tb;

  always_comb begin
    vnode    = '0;
    victim_o = '0;
    vb       = 1'b0;
    for (int unsigned i = 0; i < tplru_pkg::DEPTH; i++) begin
      vb       = bits_i[vnode];
      victim_o = {victim_o[tplru_pkg::WAY_W-2:0], vb};
      vnode    = {vnode[tplru_pkg::NODE_W-2:0], 1'b0} + tplru_pkg::NODE_W'(1)
                 + tplru_pkg::NODE_W'(vb);
    end
  end

  // Each node on the path points away from the touched way.
  always_comb begin
    tnode  = '0;
    bits_o = bits_i;
    tb     = 1'b0;
    for (int unsigned i = 0; i < tplru_pkg::DEPTH; i++) begin
      tb            = way_i[tplru_pkg::DEPTH-1-i];
      bits_o[tnode] = ~tb;
      tnode         = {tnode[tplru_pkg::NODE_W-2:0], 1'b0} + tplru_pkg::NODE_W'(1)
                      + tplru_pkg::NODE_W'(tb);
    end
  end

endmodule

[src/tree_plru_replacement_core.sv]
// Top level of the tree pseudo-LRU replacement core.
// Depends on tplru_pkg, tplru_ram and tplru_tree.
//
// Keeps a 15-bit pseudo-LRU tree for each of 2048 sets of a 16-way cache in one
// synchronous RAM. A request word carries a set and a way with a kind in tuser:
// a query returns the victim way of the set, a touch marks the way as recently
// used and returns nothing. After reset the core sweeps the RAM to zero, one set
// a cycle, with s_axis_tready low. After that one request word is taken every
// cycle: the RAM read is registered, the walk and write-back follow in the read
// stage, and a touch followed at once by a request to the same set is served
// through a forwarding register. Query results leave from an output register
// behind the read stage; only a stalled result held on the output together with
// a waiting query stops intake.
module tree_plru_replacement_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] set_index, [14:11] way, [15] zero
  input  logic       s_axis_tuser,    // [0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata     // [3:0] victim_way, [7:4] zero
);

  localparam int unsigned SET_W = tplru_pkg::SET_W;
  localparam int unsigned WAY_W = tplru_pkg::WAY_W;

  logic [tplru_pkg::CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic                        clearing;

  logic             s1_valid_q, s1_valid_d;
  tplru_pkg::req_t  s1_req_q;
  tplru_pkg::req_t  in_req;
  logic             s1_done;
  logic             in_fire;

  logic             fwd_q, fwd_d;
  tplru_pkg::tree_t fwd_bits_q;

  logic             out_valid_q, out_valid_d;
  logic [WAY_W-1:0] out_victim_q;

  tplru_pkg::tree_t rdata;
  tplru_pkg::tree_t cur_bits;
  tplru_pkg::tree_t new_bits;
  logic [WAY_W-1:0] victim;
  logic             touch_wr;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  tplru_pkg::tree_t ram_wdata;

  assign clearing = ~clr_cnt_q[tplru_pkg::CLR_W-1];

  assign in_req.op        = tplru_pkg::op_e'(s_axis_tuser);
  assign in_req.set_index = s_axis_tdata[SET_W-1:0];
  assign in_req.way       = s_axis_tdata[SET_W+WAY_W-1:SET_W];

  assign s1_done  = s1_valid_q &&
                    (s1_req_q.op == tplru_pkg::OP_TOUCH || !out_valid_q || m_axis_tready);
  assign touch_wr = s1_done && s1_req_q.op == tplru_pkg::OP_TOUCH;

  assign s_axis_tready = !clearing && (!s1_valid_q || s1_done);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cur_bits = fwd_q ? fwd_bits_q : rdata;

  tplru_tree u_tree (
    .bits_i   (cur_bits),
    .way_i    (s1_req_q.way),
    .victim_o (victim),
    .bits_o   (new_bits)
  );

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q[SET_W-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = touch_wr;
      ram_waddr = s1_req_q.set_index;
      ram_wdata = new_bits;
    end
  end

  tplru_ram #(
    .WIDTH (tplru_pkg::TREE_W),
    .DEPTH (tplru_pkg::SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_req.set_index),
    .rdata_o (rdata)
  );

  always_comb begin
    clr_cnt_d   = clearing ? clr_cnt_q + tplru_pkg::CLR_W'(1) : clr_cnt_q;
    s1_valid_d  = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_valid_q);
    fwd_d       = in_fire ? (touch_wr && s1_req_q.set_index == in_req.set_index) : fwd_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (s1_done && s1_req_q.op == tplru_pkg::OP_QUERY) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q   <= in_req;
      fwd_bits_q <= new_bits;
    end
    if (s1_done && s1_req_q.op == tplru_pkg::OP_QUERY) begin
      out_victim_q <= victim;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(8 - WAY_W)'(0), out_victim_q};

endmodule
